/* rtl/c3c_pkg.sv */
// ----------------------------------------------------------------------------
// c3c_pkg
// Shared types and constants of the 3x3 convolution core: pixel and register
// widths, register indexes, row store word and window layout.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package c3c_pkg;

	localparam int PIX_W      = 8;
	localparam int IMG_W_BITS = 11;
	localparam int IMG_H_BITS = 12;
	localparam int REG_IDX_W  = 3;

	localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;

	localparam logic [IMG_W_BITS-1:0] IMG_W_RESET = 11'd1024;
	localparam logic [IMG_H_BITS-1:0] IMG_H_RESET = 12'd768;
	localparam int KERNEL_TOP_RESET = 0;
	localparam int KERNEL_MID_RESET = 256;
	localparam int KERNEL_BOT_RESET = 0;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_IMAGE_WIDTH = 3'd0,
		REG_IMAGE_HEIGHT = 3'd1,
		REG_KERNEL_TOP = 3'd2,
		REG_KERNEL_MID = 3'd3,
		REG_KERNEL_BOT = 3'd4
	} cfg_reg_t;

	// One row store word: the latest row and the row before it at one column.
	typedef struct packed {
		logic [PIX_W-1:0] newer;
		logic [PIX_W-1:0] older;
	} pair_t;

	// 3x3 window, element i*3+j is row i (0 = top), column j (0 = left).
	typedef logic [8:0][PIX_W-1:0] win_t;

endpackage

`default_nettype wire

/* rtl/c3c_row_store.sv */
// ----------------------------------------------------------------------------
// c3c_row_store
// Two-row line buffer: one write port, two registered read ports with
// write-first bypass for a read of the address written at the same edge.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module c3c_row_store #(
	parameter int DEPTH = 1024,
	parameter int AW    = 10
) (
	input  wire logic            clk,
	input  wire logic            we,
	input  wire logic [AW-1:0]   waddr,
	input  wire c3c_pkg::pair_t  wdata,
	input  wire logic            re,
	input  wire logic [AW-1:0]   raddr_a,
	input  wire logic [AW-1:0]   raddr_b,
	output c3c_pkg::pair_t       rdata_a,
	output c3c_pkg::pair_t       rdata_b
);

	c3c_pkg::pair_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_a <= (we && waddr == raddr_a) ? wdata : mem[raddr_a];
			rdata_b <= (we && waddr == raddr_b) ? wdata : mem[raddr_b];
		end
	end

endmodule

`default_nettype wire

/* rtl/c3c_conv.sv */
// ----------------------------------------------------------------------------
// c3c_conv
// Nine-tap multiply-accumulate of a 3x3 window with the flipped kernel,
// clamped to the 8-bit pixel range.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module c3c_conv #(
	parameter int COEF_BITS = 8
) (
	input  c3c_pkg::win_t                      win,
	input  wire logic [3*COEF_BITS-1:0]        k_top,
	input  wire logic [3*COEF_BITS-1:0]        k_mid,
	input  wire logic [3*COEF_BITS-1:0]        k_bot,
	output logic [c3c_pkg::PIX_W-1:0]          pix
);

	localparam int KW = 3 * COEF_BITS;
	localparam int PW = COEF_BITS + c3c_pkg::PIX_W + 1;
	localparam int SW = PW + 4;

	logic [KW-1:0]         krow [3];
	logic signed [SW-1:0]  sum;

	assign krow[0] = k_top;
	assign krow[1] = k_mid;
	assign krow[2] = k_bot;

	always_comb begin
		logic signed [COEF_BITS-1:0] cf;
		logic signed [PW-1:0]        prod;
		sum = '0;
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				// flipped kernel: window (i,j) meets coefficient (2-i,2-j)
				cf   = $signed(krow[2-i][(2-j)*COEF_BITS +: COEF_BITS]);
				prod = $signed({1'b0, win[i*3+j]}) * cf;
				sum  = sum + SW'(prod);
			end
		end
	end

	always_comb begin
		if (sum < 0) begin
			pix = '0;
		end else if (sum > $signed({{(SW-c3c_pkg::PIX_W){1'b0}}, c3c_pkg::PIX_MAX})) begin
			pix = c3c_pkg::PIX_MAX;
		end else begin
			pix = sum[c3c_pkg::PIX_W-1:0];
		end
	end

endmodule

`default_nettype wire

/* rtl/conv3x3_replicate_border_clamp_core.sv */
// ----------------------------------------------------------------------------
// conv3x3_replicate_border_clamp_core
// Streaming 3x3 convolution with replicated borders and 0..255 clamp.
// ----------------------------------------------------------------------------
//  Channel   Dir  Signals                          Contents
//  s_axis    in   tvalid tready tdata[7:0] tuser   tdata: pixel_in; tuser: func
//  m_axis    out  tvalid tready tdata[7:0] tlast   tdata: result_pixel;
//                 tuser                            tlast: end_of_frame;
//                                                  tuser: last_of_run
//  cfg       in   cfg_we cfg_index cfg_data        register writes, no read-back
//
//  One item per cycle while m_axis accepts; an item that closes a row gives two
//  results and holds s_axis_tready low until the second is loaded, since both
//  results go through the one convolution unit. Each result passes through
//  the item stage and then the result register.
//  Reset clears counters, handshake state and the configuration registers;
//  the row store is not cleared and there is no clearing pass.
//  m_axis_tready low stalls the item stage, which then drops s_axis_tready.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module conv3x3_replicate_border_clamp_core #(
	parameter int MAX_WIDTH = 1024,
	parameter int COEF_BITS = 8
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 s_axis_tvalid,
	output logic                                      s_axis_tready,
	input  wire logic [7:0]                           s_axis_tdata,   // [7:0] pixel_in
	input  wire logic                                 s_axis_tuser,   // [0] func
	output logic                                      m_axis_tvalid,
	input  wire logic                                 m_axis_tready,
	output logic [7:0]                                m_axis_tdata,   // [7:0] result_pixel
	output logic                                      m_axis_tlast,
	output logic                                      m_axis_tuser,   // [0] last_of_run
	input  wire logic                                 cfg_we,
	input  wire logic [c3c_pkg::REG_IDX_W-1:0]        cfg_index,
	input  wire logic [((3*COEF_BITS > 12) ? 3*COEF_BITS : 12)-1:0] cfg_data
);

	localparam int CW   = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int WW   = $clog2(MAX_WIDTH + 1);
	localparam int CNTW = WW + 1;
	localparam int KW   = 3 * COEF_BITS;
	localparam int HB   = c3c_pkg::IMG_H_BITS;

	// configuration registers
	logic [c3c_pkg::IMG_W_BITS-1:0] width_q;
	logic [HB-1:0]                  height_q;
	logic [KW-1:0]                  k_top_q;
	logic [KW-1:0]                  k_mid_q;
	logic [KW-1:0]                  k_bot_q;

	// frame counters
	logic [CW-1:0] col_q;
	logic [HB-1:0] row_q;
	logic [CW-1:0] drain_q;

	logic [WW-1:0] eff_w;
	logic [HB-1:0] eff_h;
	logic          s_fire;
	logic          in_drain;
	logic          pixel_ok;
	logic          drain_ok;
	logic          col_end;
	logic          drain_last;
	logic          emit1;
	logic          emit2;

	// item stage
	logic          valid_s1;
	logic          drain_s1;
	logic [7:0]    pixel_s1;
	logic          col0_s1;
	logic          topsel_s1;
	logic          res1_s1;
	logic          res2_s1;
	logic          last_s1;
	logic          d0_s1;
	logic [CW-1:0] waddr_s1;
	logic          ph2_q;

	logic           p1_go;
	logic           p2_go;
	logic           s1_done;
	logic           out_free;
	logic           out_load;

	c3c_pkg::win_t  window_q;
	c3c_pkg::pair_t drain_left_q;
	c3c_pkg::pair_t rd_a;
	c3c_pkg::pair_t rd_b;
	c3c_pkg::pair_t wr_pair;
	c3c_pkg::pair_t left_pair;
	c3c_pkg::win_t  win_pix;
	c3c_pkg::win_t  win_edge;
	c3c_pkg::win_t  win_drn;
	c3c_pkg::win_t  win_sel;
	logic [7:0]     conv_pix;
	logic [CW-1:0]  raddr_a;
	logic [CW-1:0]  raddr_b;

	logic       out_valid_q;
	logic [7:0] out_pix_q;
	logic       out_eof_q;
	logic       out_last_q;

	// ---------------- configuration ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= c3c_pkg::IMG_W_RESET;
			height_q <= c3c_pkg::IMG_H_RESET;
			k_top_q  <= KW'(c3c_pkg::KERNEL_TOP_RESET);
			k_mid_q  <= KW'(c3c_pkg::KERNEL_MID_RESET);
			k_bot_q  <= KW'(c3c_pkg::KERNEL_BOT_RESET);
		end else if (cfg_we) begin
			case (c3c_pkg::cfg_reg_t'(cfg_index))
				c3c_pkg::REG_IMAGE_WIDTH:  width_q  <= cfg_data[c3c_pkg::IMG_W_BITS-1:0];
				c3c_pkg::REG_IMAGE_HEIGHT: height_q <= cfg_data[HB-1:0];
				c3c_pkg::REG_KERNEL_TOP:   k_top_q  <= cfg_data[KW-1:0];
				c3c_pkg::REG_KERNEL_MID:   k_mid_q  <= cfg_data[KW-1:0];
				c3c_pkg::REG_KERNEL_BOT:   k_bot_q  <= cfg_data[KW-1:0];
				default: ;
			endcase
		end
	end

	// zero width counts as one, oversize saturates
	always_comb begin
		if (width_q == '0) begin
			eff_w = WW'(1);
		end else if (int'(width_q) > MAX_WIDTH) begin
			eff_w = WW'(MAX_WIDTH);
		end else begin
			eff_w = WW'(width_q);
		end
		eff_h = (height_q == '0) ? HB'(1) : height_q;
	end

	// ---------------- input decode ----------------
	assign s_fire     = s_axis_tvalid && s_axis_tready;
	assign in_drain   = s_axis_tuser;
	assign pixel_ok   = row_q < eff_h;
	assign drain_ok   = !pixel_ok;
	assign col_end    = (CNTW'(col_q) + CNTW'(1)) >= CNTW'(eff_w);
	assign drain_last = (CNTW'(drain_q) + CNTW'(1)) >= CNTW'(eff_w);
	assign emit1      = (row_q != '0) && (col_q != '0 || col_end);
	assign emit2      = emit1 && col_end && (col_q != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q   <= '0;
			row_q   <= '0;
			drain_q <= '0;
		end else if (s_fire) begin
			if (!in_drain && pixel_ok) begin
				if (col_end) begin
					col_q <= '0;
					row_q <= row_q + HB'(1);
				end else begin
					col_q <= col_q + CW'(1);
				end
			end else if (in_drain && drain_ok) begin
				if (drain_last) begin
					col_q   <= '0;
					row_q   <= '0;
					drain_q <= '0;
				end else begin
					drain_q <= drain_q + CW'(1);
				end
			end
		end
	end

	// ---------------- row store ----------------
	// drain reads center and right column; the left one is the previous center
	assign raddr_a = in_drain ? drain_q : col_q;
	assign raddr_b = drain_last ? drain_q : drain_q + CW'(1);

	assign wr_pair = '{newer: pixel_s1, older: rd_a.newer};

	c3c_row_store #(
		.DEPTH (MAX_WIDTH),
		.AW    (CW)
	) u_row_store (
		.clk     (clk),
		.we      (p1_go && !drain_s1),
		.waddr   (waddr_s1),
		.wdata   (wr_pair),
		.re      (s_fire),
		.raddr_a (raddr_a),
		.raddr_b (raddr_b),
		.rdata_a (rd_a),
		.rdata_b (rd_b)
	);

	// ---------------- item stage ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_fire) begin
			valid_s1 <= in_drain ? drain_ok : pixel_ok;
		end else if (s1_done) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_fire) begin
			drain_s1  <= in_drain;
			pixel_s1  <= s_axis_tdata;
			col0_s1   <= (col_q == '0);
			topsel_s1 <= in_drain ? (row_q <= HB'(1)) : (row_q == HB'(1));
			res1_s1   <= in_drain ? 1'b1 : emit1;
			res2_s1   <= in_drain ? 1'b0 : emit2;
			last_s1   <= in_drain && drain_last;
			d0_s1     <= (drain_q == '0);
			waddr_s1  <= col_q;
		end
	end

	assign out_free = !out_valid_q || m_axis_tready;
	assign p1_go    = valid_s1 && !ph2_q && (!res1_s1 || out_free);
	assign p2_go    = ph2_q && out_free;
	assign s1_done  = (p1_go && !res2_s1) || p2_go;
	assign out_load = (p1_go && res1_s1) || p2_go;

	assign s_axis_tready = !valid_s1 || s1_done;

	// second result of a row end: hold the stage until it is loaded
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph2_q <= 1'b0;
		end else if (p1_go && res2_s1) begin
			ph2_q <= 1'b1;
		end else if (p2_go) begin
			ph2_q <= 1'b0;
		end
	end

	// ---------------- windows ----------------
	assign left_pair = d0_s1 ? rd_a : drain_left_q;

	always_comb begin
		logic [7:0] v;
		for (int i = 0; i < 3; i++) begin
			case (i)
				0:       v = topsel_s1 ? rd_a.newer : rd_a.older;
				1:       v = rd_a.newer;
				default: v = pixel_s1;
			endcase
			win_pix[i*3+2] = v;
			win_pix[i*3+1] = col0_s1 ? v : window_q[i*3+2];
			win_pix[i*3]   = col0_s1 ? v : window_q[i*3+1];
			// replicate the right edge column
			win_edge[i*3]   = window_q[i*3+1];
			win_edge[i*3+1] = window_q[i*3+2];
			win_edge[i*3+2] = window_q[i*3+2];
		end
		win_drn[0] = topsel_s1 ? left_pair.newer : left_pair.older;
		win_drn[1] = topsel_s1 ? rd_a.newer : rd_a.older;
		win_drn[2] = topsel_s1 ? rd_b.newer : rd_b.older;
		win_drn[3] = left_pair.newer;
		win_drn[4] = rd_a.newer;
		win_drn[5] = rd_b.newer;
		win_drn[6] = left_pair.newer;
		win_drn[7] = rd_a.newer;
		win_drn[8] = rd_b.newer;
		if (ph2_q) begin
			win_sel = win_edge;
		end else if (drain_s1) begin
			win_sel = win_drn;
		end else begin
			win_sel = win_pix;
		end
	end

	always_ff @(posedge clk) begin
		if (p1_go && !drain_s1) begin
			window_q <= win_pix;
		end
		if (p1_go && drain_s1) begin
			drain_left_q <= rd_a;
		end
	end

	c3c_conv #(
		.COEF_BITS (COEF_BITS)
	) u_conv (
		.win   (win_sel),
		.k_top (k_top_q),
		.k_mid (k_mid_q),
		.k_bot (k_bot_q),
		.pix   (conv_pix)
	);

	// ---------------- result register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_pix_q  <= conv_pix;
			out_eof_q  <= last_s1 && !ph2_q;
			out_last_q <= ph2_q || !res2_s1;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_pix_q;
	assign m_axis_tlast  = out_eof_q;
	assign m_axis_tuser  = out_last_q;

	// ---------------- assertions ----------------
	a_ph2_pixel: assert property (@(posedge clk) disable iff (!arst_n)
		ph2_q |-> (valid_s1 && !drain_s1))
		else $error("second result phase without a pixel item");

	a_ph2_block: assert property (@(posedge clk) disable iff (!arst_n)
		(ph2_q && !p2_go) |-> !s_axis_tready)
		else $error("input taken before the second result left");

	a_eof_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tlast) |-> m_axis_tuser)
		else $error("end of frame not marked as last of run");

	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		(int'(col_q) < MAX_WIDTH) && (int'(drain_q) < MAX_WIDTH))
		else $error("column counter beyond row store depth");

endmodule

`default_nettype wire

/* dv/conv_tb_pkg.sv */
// ----------------------------------------------------------------------------
// conv_tb_pkg
// Item kinds of the 3x3 convolution input stream, shared by the stimulus and
// the result checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package conv_tb_pkg;

	// s_axis_tuser: what the input transfer carries
	typedef enum logic {
		FUNC_PIXEL = 1'b0,
		FUNC_DRAIN = 1'b1
	} func_t;

endpackage

/* dv/conv_stream_checker.sv */
// ----------------------------------------------------------------------------
// conv_stream_checker
// Watches the pixel, result and register channels of the 3x3 convolution
// core, keeps its own copy of the line buffers, window and counters, and
// compares each result transfer with the oldest predicted output pixel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module conv_stream_checker #(
	parameter int MAX_WIDTH = 1024,
	parameter int COEF_BITS = 8,
	parameter int CFG_W     = 24
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          s_axis_tvalid,
	input  wire logic                          s_axis_tready,
	input  wire logic [7:0]                    s_axis_tdata,   // [7:0] pixel_in
	input  wire logic                          s_axis_tuser,   // [0] func
	input  wire logic                          m_axis_tvalid,
	input  wire logic                          m_axis_tready,
	input  wire logic [7:0]                    m_axis_tdata,   // [7:0] result_pixel
	input  wire logic                          m_axis_tlast,
	input  wire logic                          m_axis_tuser,   // [0] last_of_run
	input  wire logic                          cfg_we,
	input  wire logic [c3c_pkg::REG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]              cfg_data,
	output int unsigned                        pending,
	output int unsigned                        fail_count,
	output int unsigned                        results_checked
);
	import c3c_pkg::*;
	import conv_tb_pkg::*;

	typedef struct packed {
		logic [PIX_W-1:0] pixel;
		logic             frame_end;
		logic             run_end;
	} conv_res_t;

	logic [IMG_W_BITS-1:0]  width_reg;
	logic [IMG_H_BITS-1:0]  height_reg;
	logic [3*COEF_BITS-1:0] kernel_rows [3];

	logic [PIX_W-1:0] older_row [MAX_WIDTH];
	logic [PIX_W-1:0] newer_row [MAX_WIDTH];
	win_t             window;
	int unsigned      col_pos;
	int unsigned      rows_in;
	int unsigned      drained;

	conv_res_t expected_pixels [$];

	function automatic int unsigned eff_width();
		int unsigned w;
		w = width_reg;
		if (w == 0) w = 1;
		if (w > MAX_WIDTH) w = MAX_WIDTH;
		return w;
	endfunction

	function automatic int unsigned eff_height();
		return (height_reg == 0) ? 1 : height_reg;
	endfunction

	function automatic int unsigned clamp_addr(input int unsigned a);
		return (a < MAX_WIDTH) ? a : MAX_WIDTH - 1;
	endfunction

	// True convolution: kernel (a,b) weights the neighbor at offset (1-a, 1-b)
	function automatic logic [PIX_W-1:0] conv_sum(input win_t win);
		int acc;
		logic signed [COEF_BITS-1:0] k;
		acc = 0;
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				k = kernel_rows[2-i][(2-j)*COEF_BITS +: COEF_BITS];
				acc += int'(win[i*3+j]) * int'(k);
			end
		end
		if (acc < 0) acc = 0;
		if (acc > int'(PIX_MAX)) acc = int'(PIX_MAX);
		return PIX_W'(acc);
	endfunction

	task automatic apply_conv_item(input logic func, input logic [PIX_W-1:0] pix);
		int unsigned w, h, c, a, d, n;
		logic [PIX_W-1:0] o, nw, top_px;
		logic [PIX_W-1:0] v [3];
		win_t             edge_win, drain_win;
		int unsigned      cols [3];
		conv_res_t        res [2];
		logic             frame_done;
		w = eff_width();
		h = eff_height();
		n = 0;
		if (func == FUNC_PIXEL) begin
			if (rows_in < h) begin
				c = col_pos;
				a = clamp_addr(c);
				o = older_row[a];
				nw = newer_row[a];
				top_px = (rows_in == 1) ? nw : o;
				older_row[a] = nw;
				newer_row[a] = pix;
				v[0] = top_px;
				v[1] = nw;
				v[2] = pix;
				// first column replicates the left edge
				for (int i = 0; i < 3; i++) begin
					if (c == 0) begin
						window[i*3]   = v[i];
						window[i*3+1] = v[i];
					end else begin
						window[i*3]   = window[i*3+1];
						window[i*3+1] = window[i*3+2];
					end
					window[i*3+2] = v[i];
				end
				if (rows_in >= 1 && (c >= 1 || c + 1 >= w)) begin
					res[n] = '{conv_sum(window), 1'b0, 1'b0};
					n++;
					// row end: also emit the last column with right edge replicated
					if (c + 1 >= w && c >= 1) begin
						for (int i = 0; i < 3; i++) begin
							edge_win[i*3]   = window[i*3+1];
							edge_win[i*3+1] = window[i*3+2];
							edge_win[i*3+2] = window[i*3+2];
						end
						res[n] = '{conv_sum(edge_win), 1'b0, 1'b0};
						n++;
					end
				end
				if (c + 1 >= w) begin
					col_pos = 0;
					rows_in++;
				end else begin
					col_pos = c + 1;
				end
			end
		end else begin
			if (rows_in >= h) begin
				d = drained;
				frame_done = (d + 1 >= w);
				cols[0] = clamp_addr((d == 0) ? 0 : d - 1);
				cols[1] = clamp_addr(d);
				cols[2] = clamp_addr(frame_done ? d : d + 1);
				// bottom edge replicated: middle and bottom rows both from newest row
				for (int j = 0; j < 3; j++) begin
					drain_win[j]   = (rows_in <= 1) ? newer_row[cols[j]] : older_row[cols[j]];
					drain_win[3+j] = newer_row[cols[j]];
					drain_win[6+j] = newer_row[cols[j]];
				end
				res[n] = '{conv_sum(drain_win), frame_done, 1'b0};
				n++;
				if (frame_done) begin
					col_pos = 0;
					rows_in = 0;
					drained = 0;
				end else begin
					drained = d + 1;
				end
			end
		end
		if (n > 0) res[n-1].run_end = 1'b1;
		for (int k = 0; k < n; k++) expected_pixels.push_back(res[k]);
	endtask

	task automatic check_result();
		conv_res_t exp_res;
		if (expected_pixels.size() == 0) begin
			$error("result with no prediction: tdata=%0d tlast=%0b tuser=%0b",
				m_axis_tdata, m_axis_tlast, m_axis_tuser);
			fail_count++;
		end else begin
			exp_res = expected_pixels.pop_front();
			if (m_axis_tdata !== exp_res.pixel) begin
				$error("result_pixel: expected %0d, actual %0d", exp_res.pixel, m_axis_tdata);
				fail_count++;
			end
			if (m_axis_tlast !== exp_res.frame_end) begin
				$error("end_of_frame: expected %0b, actual %0b",
					exp_res.frame_end, m_axis_tlast);
				fail_count++;
			end
			if (m_axis_tuser !== exp_res.run_end) begin
				$error("last_of_run: expected %0b, actual %0b", exp_res.run_end, m_axis_tuser);
				fail_count++;
			end
			results_checked++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_reg = IMG_W_RESET;
			height_reg = IMG_H_RESET;
			kernel_rows[0] = (3*COEF_BITS)'(KERNEL_TOP_RESET);
			kernel_rows[1] = (3*COEF_BITS)'(KERNEL_MID_RESET);
			kernel_rows[2] = (3*COEF_BITS)'(KERNEL_BOT_RESET);
			for (int k = 0; k < MAX_WIDTH; k++) begin
				older_row[k] = '0;
				newer_row[k] = '0;
			end
			window = '0;
			col_pos = 0;
			rows_in = 0;
			drained = 0;
			expected_pixels.delete();
			pending = 0;
			fail_count = 0;
			results_checked = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_reg_t'(cfg_index))
					REG_IMAGE_WIDTH: begin
						width_reg = cfg_data[IMG_W_BITS-1:0];
					end
					REG_IMAGE_HEIGHT: begin
						height_reg = cfg_data[IMG_H_BITS-1:0];
					end
					REG_KERNEL_TOP: begin
						kernel_rows[0] = cfg_data[3*COEF_BITS-1:0];
					end
					REG_KERNEL_MID: begin
						kernel_rows[1] = cfg_data[3*COEF_BITS-1:0];
					end
					REG_KERNEL_BOT: begin
						kernel_rows[2] = cfg_data[3*COEF_BITS-1:0];
					end
					default: begin
					end
				endcase
			end
			if (s_axis_tvalid && s_axis_tready) apply_conv_item(s_axis_tuser, s_axis_tdata);
			if (m_axis_tvalid && m_axis_tready) check_result();
			pending = expected_pixels.size();
		end
	end

endmodule

/* dv/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the 3x3 convolution core: directed frames at the
// size, kernel and clamp extremes, a frame at an oversize width and one at the
// largest height, each cut short by a register write, then random frames
// with ignored items, mid-frame register changes and idle bursts on both
// channels. Results are checked in conv_stream_checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
	import c3c_pkg::*;
	import conv_tb_pkg::*;

	localparam int MAX_WIDTH      = 1024;
	localparam int COEF_BITS      = 8;
	localparam int CFG_W          = (3*COEF_BITS > 12) ? 3*COEF_BITS : 12;
	localparam int RESET_CYCLES   = 12;
	localparam int RANDOM_ITEMS   = 830;
	localparam int SETTLE_CYCLES  = 8;
	localparam int WATCHDOG_LIMIT = 500;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_axis_tvalid = 1'b0;
	logic                 s_axis_tready;
	logic [7:0]           s_axis_tdata = '0;
	logic                 s_axis_tuser = 1'b0;
	logic                 m_axis_tvalid;
	logic                 m_axis_tready = 1'b1;
	logic [7:0]           m_axis_tdata;
	logic                 m_axis_tlast;
	logic                 m_axis_tuser;
	logic                 cfg_we = 1'b0;
	logic [REG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_data = '0;

	int unsigned pending;
	int unsigned fail_count;
	int unsigned results_checked;

	int unsigned s_gap_pct = 0;
	int unsigned m_stall_pct = 0;
	bit          calm = 1'b0;
	int unsigned cur_w = 1;
	int unsigned cur_h = 1;
	int unsigned useful_items = 0;
	int unsigned ignored_items = 0;
	int unsigned frames = 0;
	int unsigned mid_frame_writes = 0;
	int unsigned quiet_cycles = 0;

	cfg_reg_t kernel_regs [3] = '{REG_KERNEL_TOP, REG_KERNEL_MID, REG_KERNEL_BOT};

	always #6 clk = ~clk;

	conv3x3_replicate_border_clamp_core #(
		.MAX_WIDTH(MAX_WIDTH),
		.COEF_BITS(COEF_BITS)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tlast(m_axis_tlast),
		.m_axis_tuser(m_axis_tuser),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	conv_stream_checker #(
		.MAX_WIDTH(MAX_WIDTH),
		.COEF_BITS(COEF_BITS),
		.CFG_W(CFG_W)
	) u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tlast(m_axis_tlast),
		.m_axis_tuser(m_axis_tuser),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.pending(pending),
		.fail_count(fail_count),
		.results_checked(results_checked)
	);

	// Result side backpressure: random bursts of stalled cycles, with ready
	// cycles between bursts.
	initial begin
		int burst;
		burst = 0;
		forever begin
			@(negedge clk);
			if (!calm && burst == 0 && m_axis_tready && $urandom_range(0, 99) < m_stall_pct)
				burst = $urandom_range(1, 17);
			if (burst > 0) begin
				m_axis_tready <= 1'b0;
				burst--;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Watchdog: no transfer for %0d cycles, %0d results outstanding",
				quiet_cycles, pending);
			$display("Simulation FAILED");
			$finish;
		end
	end

	// Called at a falling edge; returns at the falling edge after the transfer.
	task automatic push_item(input func_t f, input logic [7:0] p);
		int unsigned gap;
		if (!calm && $urandom_range(0, 99) < s_gap_pct) begin
			gap = $urandom_range(1, 17);
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= p;
		s_axis_tuser <= f;
		do @(posedge clk); while (!s_axis_tready);
		@(negedge clk);
	endtask

	function automatic logic [7:0] rand_pixel();
		case ($urandom_range(0, 7))
			0: return 8'h00;
			1: return 8'hFF;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	// Mostly small coefficients from -3 to 3; otherwise all 24 bits are random.
	function automatic logic [23:0] random_kernel();
		logic [23:0] k;
		k = 24'($urandom());
		if ($urandom_range(0, 3) != 0) begin
			for (int j = 0; j < 3; j++) k[j*8 +: 8] = 8'($urandom_range(0, 6)) - 8'd3;
		end
		return k;
	endfunction

	// Write only once the core is idle; unused data bits carry random values.
	task automatic write_reg(input cfg_reg_t idx, input logic [23:0] val);
		logic [CFG_W-1:0] d;
		s_axis_tvalid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		d = CFG_W'($urandom());
		case (idx)
			REG_IMAGE_WIDTH:  d[IMG_W_BITS-1:0] = val[IMG_W_BITS-1:0];
			REG_IMAGE_HEIGHT: d[IMG_H_BITS-1:0] = val[IMG_H_BITS-1:0];
			default:          d = val;
		endcase
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_size(input int unsigned w_val, input int unsigned h_val);
		write_reg(REG_IMAGE_WIDTH, 24'(w_val));
		write_reg(REG_IMAGE_HEIGHT, 24'(h_val));
		cur_w = (w_val == 0) ? 1 : ((w_val > MAX_WIDTH) ? MAX_WIDTH : w_val);
		cur_h = (h_val == 0) ? 1 : h_val;
	endtask

	// Pixels of an unfinished frame, with stray drains that the core ignores.
	task automatic send_pixels(input int unsigned count, input int unsigned noise_pct);
		for (int unsigned k = 0; k < count; k++) begin
			if ($urandom_range(0, 99) < noise_pct) begin
				push_item(FUNC_DRAIN, 8'($urandom_range(0, 255)));
				ignored_items++;
			end
			push_item(FUNC_PIXEL, rand_pixel());
			useful_items++;
		end
	endtask

	// Optional surplus pixel (ignored), then one drain per output column.
	task automatic send_drains(input int unsigned w, input int unsigned noise_pct);
		if ($urandom_range(0, 99) < noise_pct) begin
			push_item(FUNC_PIXEL, rand_pixel());
			ignored_items++;
		end
		for (int unsigned k = 0; k < w; k++) begin
			push_item(FUNC_DRAIN, 8'($urandom_range(0, 255)));
			useful_items++;
		end
		frames++;
	endtask

	// Frame with one register rewritten partway through.
	task automatic broken_frame(input int unsigned noise_pct);
		int unsigned r, c, kind, nh, nw, rest;
		r = $urandom_range(0, cur_h - 1);
		c = $urandom_range(0, cur_w - 1);
		kind = $urandom_range(0, 2);
		if (kind == 2 && cur_w == 1) kind = 0;
		mid_frame_writes++;
		case (kind)
			0: begin
				send_pixels(r * cur_w + c, noise_pct);
				write_reg(kernel_regs[$urandom_range(0, 2)], random_kernel());
				send_pixels(cur_w * cur_h - (r * cur_w + c), noise_pct);
			end
			1: begin
				// a height at or below the rows already in ends the frame at once
				send_pixels(r * cur_w, noise_pct);
				nh = $urandom_range(1, r + 2);
				write_reg(REG_IMAGE_HEIGHT, 24'(nh));
				cur_h = nh;
				if (nh > r) send_pixels((nh - r) * cur_w, noise_pct);
			end
			default: begin
				// shrink only: the current row closes at once or at the new width
				send_pixels(r * cur_w + c, noise_pct);
				nw = $urandom_range(1, cur_w - 1);
				write_reg(REG_IMAGE_WIDTH, 24'(nw));
				rest = (nw > c) ? nw - c : 1;
				send_pixels(rest + (cur_h - r - 1) * nw, noise_pct);
				cur_w = nw;
			end
		endcase
		send_drains(cur_w, noise_pct);
	endtask

	initial begin
		int unsigned random_base, w, h, noise;
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Identity kernel from reset, extreme pixels, ignored items on both ends
		set_size(3, 2);
		push_item(FUNC_DRAIN, 8'hFF);
		push_item(FUNC_PIXEL, 8'h00);
		push_item(FUNC_PIXEL, 8'hFF);
		push_item(FUNC_PIXEL, 8'h80);
		push_item(FUNC_PIXEL, 8'hFF);
		push_item(FUNC_PIXEL, 8'h00);
		push_item(FUNC_PIXEL, 8'h01);
		push_item(FUNC_PIXEL, 8'hAA);
		for (int k = 0; k < 3; k++) push_item(FUNC_DRAIN, 8'h00);

		// Zero sizes count as one; largest positive kernel saturates high
		for (int k = 0; k < 3; k++) write_reg(kernel_regs[k], 24'h7F7F7F);
		set_size(0, 0);
		push_item(FUNC_PIXEL, 8'h01);
		push_item(FUNC_DRAIN, 8'h55);

		// Most negative kernel saturates low; two columns, three rows
		for (int k = 0; k < 3; k++) write_reg(kernel_regs[k], 24'h808080);
		set_size(2, 3);
		for (int k = 0; k < 6; k++) push_item(FUNC_PIXEL, (k % 2) ? 8'hFF : 8'h00);
		push_item(FUNC_DRAIN, 8'h00);
		push_item(FUNC_DRAIN, 8'hFF);
		frames += 3;

		// Width beyond the maximum saturates: the first row runs past the new
		// width written partway through, so the next pixel closes it
		s_gap_pct = 10;
		m_stall_pct = 10;
		for (int k = 0; k < 3; k++) write_reg(kernel_regs[k], random_kernel());
		set_size(2047, 2);
		send_pixels(24, 1);
		write_reg(REG_IMAGE_WIDTH, 24'd24);
		cur_w = 24;
		mid_frame_writes++;
		send_pixels(1 + cur_w, 1);
		send_drains(cur_w, 50);

		// Largest height: a few rows in, then the height drops to end the frame
		set_size(1, 4095);
		send_pixels(3, 1);
		write_reg(REG_IMAGE_HEIGHT, 24'd3);
		cur_h = 3;
		mid_frame_writes++;
		send_drains(cur_w, 50);

		random_base = useful_items;
		while (useful_items - random_base < RANDOM_ITEMS) begin
			calm = (useful_items - random_base) > (RANDOM_ITEMS * 4 / 5);
			s_gap_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 35);
			m_stall_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 35);
			noise = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(2, 15);
			for (int k = 0; k < 3; k++) begin
				if ($urandom_range(0, 1) == 0) write_reg(kernel_regs[k], random_kernel());
			end
			// keep the size now and then so that frames run back to back
			if ($urandom_range(0, 2) != 0) begin
				w = ($urandom_range(0, 9) == 0) ? $urandom_range(11, 64) : $urandom_range(1, 10);
				h = $urandom_range(1, 6);
				if (w == 1 && $urandom_range(0, 1) == 0) w = 0;
				if (h == 1 && $urandom_range(0, 1) == 0) h = 0;
				set_size(w, h);
			end
			if ($urandom_range(0, 4) == 0) begin
				broken_frame(noise);
			end else begin
				send_pixels(cur_w * cur_h, noise);
				send_drains(cur_w, noise);
			end
		end

		s_axis_tvalid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		$display("Covered %0d frames: %0d counted input items, %0d ignored items, %0d results",
			frames, useful_items, ignored_items, results_checked);
		$display("Sizes from 1x1 up to 64x7, oversize width and largest height, %0d %s",
			mid_frame_writes, "register writes inside a frame");
		if (fail_count == 0 && pending == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
